// ----- sv/edot_pkg.sv -----
// Shared types, codes and constants of the earliest-deadline order table.
`timescale 1ns / 1ps

package edot_pkg;

    // Default number of orders the table holds.
    localparam int DEF_TABLE_DEPTH = 64;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR     = 2'd0;
    localparam logic [1:0] KIND_INSERT    = 2'd1;
    localparam logic [1:0] KIND_PART_DONE = 2'd2;

    // Deadline answered when no order matches.
    localparam logic [63:0] NONE_FOUND = 64'hFFFF_FFFF_FFFF_FFFF;

    // Part counter value after reset.
    localparam logic [15:0] PART_NUMBER_RESET = 16'd1;

    // Remaining count at or below which a counted part finishes an order.
    localparam logic [15:0] LAST_PART = 16'd1;

    // Request transaction.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] family;
        logic [15:0] part_type;
        logic [15:0] lot_size;
        logic [63:0] deadline;
    } edot_req_t;

    // Response transaction.
    typedef struct packed {
        logic [1:0]  done_kind;
        logic [63:0] earliest_deadline;
        logic [15:0] first_part_number;
        logic [15:0] family_echo;
        logic [15:0] type_echo;
        logic [15:0] lot_echo;
        logic        table_full;
    } edot_rsp_t;

    // One stored order.
    typedef struct packed {
        logic [15:0] family;
        logic [15:0] part_type;
        logic [15:0] remaining;
        logic [63:0] deadline;
    } edot_entry_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_DECREMENT,
        ST_DONE
    } edot_state_t;

endpackage

// ----- sv/edot_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module edot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/earliest_deadline_order_table_unit.sv -----
// Top level of the earliest-deadline order table.
`timescale 1ns / 1ps

// The block keeps up to TABLE_DEPTH orders in insertion order in one RAM
// and answers every clear, insert and part-done transaction with one
// response; a request of the unused kind is taken and dropped. One request
// is worked on at a time, and the request port is ready only while the
// sequencer is idle. An insert into a table that is not full writes the new
// order and then scans the N stored orders through the RAM read port, one
// entry a cycle. A part-done scans the same way; when the chosen order
// finishes, the later orders are moved down one place through the same read
// and write ports, and otherwise the decremented count is written back. A
// finished response waits in an output register, so the next request is
// taken while it is still pending. There is no clearing pass after reset.
module earliest_deadline_order_table_unit #(
    parameter int TABLE_DEPTH = edot_pkg::DEF_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  edot_pkg::edot_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output edot_pkg::edot_rsp_t rsp
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = $bits(edot_pkg::edot_entry_t);

    // Control registers.
    edot_pkg::edot_state_t state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [15:0]           part_num_reg, part_num_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic                  pend_reg, pend_next;
    logic                  found_reg, found_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // Payload registers.
    edot_pkg::edot_req_t   item_reg, item_next;
    logic [15:0]           fpn_reg, fpn_next;
    logic                  full_reg, full_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [63:0]           best_dl_reg, best_dl_next;
    logic [63:0]           second_dl_reg, second_dl_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [15:0]           best_rem_reg, best_rem_next;
    logic [63:0]           res_dl_reg, res_dl_next;
    edot_pkg::edot_rsp_t   rsp_reg, rsp_next;

    // RAM signals.
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    edot_pkg::edot_entry_t wr_entry;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [EW-1:0]         rd_data;
    edot_pkg::edot_entry_t rd_entry;

    // Handshake and sequencing conditions.
    logic req_fire;
    logic table_full;
    logic issue;
    logic sweep_done;
    logic rd_match;
    logic finishes;
    logic rsp_load;

    edot_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = edot_pkg::edot_entry_t'(rd_data);

    // Conditions shared by the sequencer and the datapath.
    assign req_ready  = (state_reg == edot_pkg::ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign issue      = ((state_reg == edot_pkg::ST_SCAN) ||
                         (state_reg == edot_pkg::ST_COMPACT)) && (ptr_reg < count_reg);
    assign sweep_done = !issue && !pend_reg;
    assign rd_match   = pend_reg && (rd_entry.family == item_reg.family) &&
                        (rd_entry.part_type == item_reg.part_type);
    assign finishes   = found_reg && (best_rem_reg <= edot_pkg::LAST_PART);
    assign rsp_load   = (state_reg == edot_pkg::ST_DONE) && (!rsp_valid_reg || rsp_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            edot_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.kind)
                        edot_pkg::KIND_CLEAR:
                        begin
                            state_next = edot_pkg::ST_DONE;
                        end
                        edot_pkg::KIND_INSERT:
                        begin
                            state_next = table_full ? edot_pkg::ST_DONE : edot_pkg::ST_SCAN;
                        end
                        edot_pkg::KIND_PART_DONE:
                        begin
                            state_next = edot_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = edot_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            edot_pkg::ST_SCAN:
            begin
                if (sweep_done)
                begin
                    if (item_reg.kind == edot_pkg::KIND_PART_DONE && found_reg)
                    begin
                        state_next = finishes ? edot_pkg::ST_COMPACT : edot_pkg::ST_DECREMENT;
                    end
                    else
                    begin
                        state_next = edot_pkg::ST_DONE;
                    end
                end
            end
            edot_pkg::ST_COMPACT:
            begin
                if (sweep_done)
                begin
                    state_next = edot_pkg::ST_DONE;
                end
            end
            edot_pkg::ST_DECREMENT:
            begin
                state_next = edot_pkg::ST_DONE;
            end
            edot_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = edot_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = edot_pkg::ST_IDLE;
            end
        endcase
    end

    // RAM port control.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = count_reg[AW-1:0];
        wr_entry = '0;
        rd_en    = issue;
        rd_addr  = ptr_reg[AW-1:0];
        case (state_reg)
            edot_pkg::ST_IDLE:
            begin
                // Append a new order at the end of the table.
                wr_en              = req_fire && (req.kind == edot_pkg::KIND_INSERT) &&
                                     !table_full;
                wr_addr            = count_reg[AW-1:0];
                wr_entry.family    = req.family;
                wr_entry.part_type = req.part_type;
                wr_entry.remaining = req.lot_size;
                wr_entry.deadline  = req.deadline;
            end
            edot_pkg::ST_COMPACT:
            begin
                // Move each later order down by one place.
                wr_en    = pend_reg;
                wr_addr  = AW'(idx_reg - AW'(1));
                wr_entry = rd_entry;
            end
            edot_pkg::ST_DECREMENT:
            begin
                // Count one part off the chosen order.
                wr_en              = 1'b1;
                wr_addr            = best_idx_reg;
                wr_entry.family    = item_reg.family;
                wr_entry.part_type = item_reg.part_type;
                wr_entry.remaining = best_rem_reg - 16'd1;
                wr_entry.deadline  = best_dl_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        count_next     = count_reg;
        part_num_next  = part_num_reg;
        ptr_next       = ptr_reg;
        pend_next      = issue;
        found_next     = found_reg;
        item_next      = item_reg;
        fpn_next       = fpn_reg;
        full_next      = full_reg;
        idx_next       = issue ? ptr_reg[AW-1:0] : idx_reg;
        best_dl_next   = best_dl_reg;
        second_dl_next = second_dl_reg;
        best_idx_next  = best_idx_reg;
        best_rem_next  = best_rem_reg;
        res_dl_next    = res_dl_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        if (issue)
        begin
            ptr_next = ptr_reg + CW'(1);
        end

        case (state_reg)
            edot_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    item_next      = req;
                    ptr_next       = '0;
                    found_next     = 1'b0;
                    best_dl_next   = edot_pkg::NONE_FOUND;
                    second_dl_next = edot_pkg::NONE_FOUND;
                    full_next      = 1'b0;
                    fpn_next       = '0;
                    res_dl_next    = '0;
                    case (req.kind)
                        edot_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        edot_pkg::KIND_INSERT:
                        begin
                            fpn_next      = part_num_reg;
                            part_num_next = part_num_reg + req.lot_size;
                            if (table_full)
                            begin
                                full_next   = 1'b1;
                                res_dl_next = edot_pkg::NONE_FOUND;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            edot_pkg::ST_SCAN:
            begin
                // Strictly earlier deadlines win, so ties keep the oldest order.
                if (rd_match && (rd_entry.deadline < best_dl_reg))
                begin
                    found_next     = 1'b1;
                    best_dl_next   = rd_entry.deadline;
                    second_dl_next = best_dl_reg;
                    best_idx_next  = idx_reg;
                    best_rem_next  = rd_entry.remaining;
                end
                else if (rd_match && (rd_entry.deadline < second_dl_reg))
                begin
                    second_dl_next = rd_entry.deadline;
                end
                if (sweep_done)
                begin
                    res_dl_next = (item_reg.kind == edot_pkg::KIND_PART_DONE && finishes) ?
                                  second_dl_reg : best_dl_reg;
                    ptr_next    = CW'(best_idx_reg) + CW'(1);
                end
            end
            edot_pkg::ST_COMPACT:
            begin
                if (sweep_done)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            edot_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_next                   = '0;
                    rsp_next.done_kind         = item_reg.kind;
                    rsp_next.earliest_deadline = res_dl_reg;
                    rsp_next.table_full        = full_reg;
                    if (item_reg.kind == edot_pkg::KIND_INSERT)
                    begin
                        rsp_next.first_part_number = fpn_reg;
                        rsp_next.family_echo       = item_reg.family;
                        rsp_next.type_echo         = item_reg.part_type;
                        rsp_next.lot_echo          = item_reg.lot_size;
                    end
                end
            end
            default:
            begin
                found_next = found_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edot_pkg::ST_IDLE;
            count_reg     <= '0;
            part_num_reg  <= edot_pkg::PART_NUMBER_RESET;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            part_num_reg  <= part_num_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        fpn_reg       <= fpn_next;
        full_reg      <= full_next;
        idx_reg       <= idx_next;
        best_dl_reg   <= best_dl_next;
        second_dl_reg <= second_dl_next;
        best_idx_reg  <= best_idx_next;
        best_rem_reg  <= best_rem_next;
        res_dl_reg    <= res_dl_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- verif/earliest_deadline_order_table_unit_tb.sv -----
// Self-checking testbench for the earliest-deadline order table with random handshake gaps.
`timescale 1ns / 1ps

module earliest_deadline_order_table_unit_tb;

    localparam int         TABLE_DEPTH   = edot_pkg::DEF_TABLE_DEPTH;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET   = 1550;
    localparam int         CALM_TAIL     = 150;
    localparam int         SETTLE_CYCLES = 160;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         PAIR_COUNT    = 4;

    logic                logic_unused_guard_n;
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    edot_pkg::edot_req_t req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    edot_pkg::edot_rsp_t rsp;

    // Request transactions still to be sent and responses still to arrive.
    edot_pkg::edot_req_t   pending_requests[$];
    edot_pkg::edot_rsp_t   awaited_answers[$];

    // Shadow copy of the order table and the part counter.
    edot_pkg::edot_entry_t orders[TABLE_DEPTH];
    int                    order_count = 0;
    logic [15:0]           next_part   = edot_pkg::PART_NUMBER_RESET;

    int          queued_items      = 0;
    int          total_requests    = 0;
    int          accepted_requests = 0;
    bit          req_taken         = 1'b0;
    int          send_gap          = 0;
    int          stall_left        = 0;
    bit          run_failed        = 1'b0;
    int          cycle_count       = 0;
    logic [15:0] pair_family[PAIR_COUNT];
    logic [15:0] pair_type[PAIR_COUNT];

    earliest_deadline_order_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    assign logic_unused_guard_n = rst_n;

    always #1 clk = ~clk;

    // Index of the earliest-deadline order of a family and type, oldest on a tie, or -1.
    function automatic int earliest_order(input logic [15:0] fam, input logic [15:0] typ);
        int          best;
        logic [63:0] best_dl;
        int          i;
        best    = -1;
        best_dl = edot_pkg::NONE_FOUND;
        for (i = 0; i < order_count; i++)
        begin
            if (orders[i].family == fam && orders[i].part_type == typ &&
                orders[i].deadline < best_dl)
            begin
                best    = i;
                best_dl = orders[i].deadline;
            end
        end
        return best;
    endfunction

    // Update the shadow table for one accepted request and queue the response it must give.
    task automatic predict_answer(input edot_pkg::edot_req_t r);
        edot_pkg::edot_rsp_t ans;
        int                  pick;
        int                  i;
        if (r.kind == KIND_UNUSED)
            return;
        ans           = '0;
        ans.done_kind = r.kind;
        case (r.kind)
            edot_pkg::KIND_CLEAR:
            begin
                order_count = 0;
            end
            edot_pkg::KIND_INSERT:
            begin
                if (order_count >= TABLE_DEPTH)
                begin
                    ans.earliest_deadline = edot_pkg::NONE_FOUND;
                    ans.table_full        = 1'b1;
                end
                else
                begin
                    orders[order_count].family    = r.family;
                    orders[order_count].part_type = r.part_type;
                    orders[order_count].remaining = r.lot_size;
                    orders[order_count].deadline  = r.deadline;
                    order_count++;
                    pick = earliest_order(r.family, r.part_type);
                    ans.earliest_deadline = (pick < 0) ? edot_pkg::NONE_FOUND :
                                            orders[pick].deadline;
                end
                ans.first_part_number = next_part;
                ans.family_echo       = r.family;
                ans.type_echo         = r.part_type;
                ans.lot_echo          = r.lot_size;
                next_part             = next_part + r.lot_size;
            end
            default:
            begin
                // One part finished: count it off the earliest matching order.
                pick = earliest_order(r.family, r.part_type);
                if (pick >= 0)
                begin
                    if (orders[pick].remaining <= edot_pkg::LAST_PART)
                    begin
                        for (i = pick; i + 1 < order_count; i++)
                            orders[i] = orders[i + 1];
                        order_count--;
                        pick = earliest_order(r.family, r.part_type);
                    end
                    else
                    begin
                        orders[pick].remaining = orders[pick].remaining - 16'd1;
                    end
                end
                ans.earliest_deadline = (pick < 0) ? edot_pkg::NONE_FOUND :
                                        orders[pick].deadline;
            end
        endcase
        awaited_answers = {awaited_answers, ans};
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            run_failed = 1'b1;
        end
    endtask

    task automatic queue_request(input logic [1:0] kind, input logic [15:0] fam,
                                 input logic [15:0] typ, input logic [15:0] lot,
                                 input logic [63:0] dl);
        edot_pkg::edot_req_t r;
        r.kind      = kind;
        r.family    = fam;
        r.part_type = typ;
        r.lot_size  = lot;
        r.deadline  = dl;
        pending_requests = {pending_requests, r};
        if (kind != KIND_UNUSED)
            queued_items++;
    endtask

    // Mostly small deadlines so that ties occur, sometimes all ones or fully random.
    function automatic logic [63:0] random_deadline();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 64'($urandom_range(0, 15));
        if (roll < 56)
            return edot_pkg::NONE_FOUND;
        return {$urandom, $urandom};
    endfunction

    // Mostly short lots so that orders finish within a few parts.
    function automatic logic [15:0] random_lot();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 16'($urandom_range(0, 3));
        if (roll < 90)
            return 16'($urandom_range(4, 20));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] random_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return 16'h0000;
        if (roll < 4)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic pick_pairs();
        int p;
        for (p = 0; p < PAIR_COUNT; p++)
        begin
            pair_family[p] = random_key();
            pair_type[p]   = random_key();
        end
        // Two pairs sharing a family keep the type comparison honest.
        pair_family[1] = pair_family[0];
    endtask

    task automatic queue_order_on_pair();
        int p;
        p = $urandom_range(0, PAIR_COUNT - 1);
        queue_request(edot_pkg::KIND_INSERT, pair_family[p], pair_type[p], random_lot(),
                      random_deadline());
    endtask

    task automatic queue_part_on_pair();
        int p;
        p = $urandom_range(0, PAIR_COUNT - 1);
        queue_request(edot_pkg::KIND_PART_DONE, pair_family[p], pair_type[p], 16'($urandom),
                      {$urandom, $urandom});
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        bit first_episode;
        int roll;

        // Directed: empty table, ties, all-ones deadlines, lot sizes 0 and 1, counter wrap.
        queue_request(edot_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      edot_pkg::NONE_FOUND);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0000, 16'h0000, 16'h0000, 64'd0);
        queue_request(edot_pkg::KIND_INSERT, 16'h0000, 16'h0000, 16'd0, 64'd5);
        queue_request(edot_pkg::KIND_INSERT, 16'h0000, 16'h0000, 16'd3, 64'd5);
        queue_request(edot_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      edot_pkg::NONE_FOUND);
        queue_request(edot_pkg::KIND_PART_DONE, 16'hFFFF, 16'hFFFF, 16'h1234, 64'd9);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0000, 16'h0000, 16'hFFFF,
                      edot_pkg::NONE_FOUND);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0000, 16'h0000, 16'h0000, 64'd0);
        queue_request(edot_pkg::KIND_INSERT, 16'h0000, 16'h0000, 16'd1, 64'd0);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0000, 16'h0000, 16'h5555,
                      64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, edot_pkg::NONE_FOUND);
        queue_request(edot_pkg::KIND_INSERT, 16'h0000, 16'hFFFF, 16'd2,
                      64'hFFFF_FFFF_FFFF_FFFE);
        queue_request(edot_pkg::KIND_INSERT, 16'hFFFF, 16'h0000, 16'd1, 64'd0);
        queue_request(edot_pkg::KIND_PART_DONE, 16'hFFFF, 16'h0000, 16'd7, 64'd1);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0000, 16'hFFFF, 16'd0, 64'd0);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0000, 16'hFFFF, 16'd0, 64'd0);
        queue_request(edot_pkg::KIND_INSERT, 16'h0001, 16'h0002, 16'hFFFF, 64'd1);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0001, 16'h0002, 16'd0, 64'd0);
        queue_request(edot_pkg::KIND_INSERT, 16'h8000, 16'h8000, 16'h8000,
                      64'h8000_0000_0000_0000);
        queue_request(edot_pkg::KIND_CLEAR, 16'h1234, 16'h5678, 16'h9ABC,
                      64'hDEAD_BEEF_0123_4567);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h0001, 16'h0002, 16'd0, 64'd0);
        queue_request(edot_pkg::KIND_PART_DONE, 16'h8000, 16'h8000, 16'd0, 64'd0);

        // Random episodes: mostly orders and parts on a few pairs, sometimes a full table.
        first_episode = 1'b1;
        while (queued_items < ITEM_TARGET)
        begin
            pick_pairs();
            if (first_episode || $urandom_range(0, 5) == 0)
            begin
                queue_request(edot_pkg::KIND_CLEAR, random_key(), random_key(), random_lot(),
                              random_deadline());
                repeat ($urandom_range(60, 70)) queue_order_on_pair();
                repeat ($urandom_range(10, 30)) queue_part_on_pair();
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_request(edot_pkg::KIND_CLEAR, random_key(), random_key(),
                                  random_lot(), random_deadline());
                repeat ($urandom_range(1, 12)) queue_order_on_pair();
                repeat ($urandom_range(10, 40))
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60)
                        queue_part_on_pair();
                    else if (roll < 85)
                        queue_order_on_pair();
                    else if (roll < 92)
                        queue_request(edot_pkg::KIND_PART_DONE, random_key(), random_key(),
                                      random_lot(), random_deadline());
                    else if (roll < 97)
                        queue_request(KIND_UNUSED, random_key(), random_key(), random_lot(),
                                      random_deadline());
                    else
                        queue_request(edot_pkg::KIND_CLEAR, random_key(), random_key(),
                                      random_lot(), random_deadline());
                end
            end
            first_episode = 1'b0;
        end
        total_requests = pending_requests.size();

        // Hold reset, then release it on a falling edge, away from the rising edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_requests < total_requests)
            @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (run_failed)
        begin
            $display("FAIL");
        end
        else
        begin
            $display("PASS");
        end
        $finish;
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Request driver: presents the next transaction once the last one was taken.
    always @(negedge clk)
    begin
        edot_pkg::edot_req_t next_req;
        logic                next_valid;
        next_req   = req;
        next_valid = req_valid;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            next_valid = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_requests.size() > 0)
            begin
                next_req   = pending_requests.pop_front();
                next_valid = 1'b1;
                if (pending_requests.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 10);
            end
        end
        req_valid <= next_valid;
        req       <= next_req;
    end

    // Response receiver: stalls in random bursts except near the end.
    always @(negedge clk)
    begin
        logic next_ready;
        next_ready = 1'b1;
        if (stall_left > 0)
        begin
            stall_left--;
            next_ready = 1'b0;
        end
        else if (rst_n && pending_requests.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            next_ready = 1'b0;
        end
        rsp_ready <= next_ready;
    end

    // Monitor: predicts on every accepted request and checks every accepted response.
    always @(posedge clk)
    begin
        edot_pkg::edot_rsp_t want;
        if (rst_n && req_valid && req_ready)
        begin
            predict_answer(req);
            accepted_requests++;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_answers.size() == 0)
            begin
                $error("response %h arrived with no transaction awaiting it", rsp);
                run_failed = 1'b1;
            end
            else
            begin
                want = awaited_answers.pop_front();
                check_field("done_kind", 64'(want.done_kind), 64'(rsp.done_kind));
                check_field("earliest_deadline", want.earliest_deadline,
                            rsp.earliest_deadline);
                check_field("first_part_number", 64'(want.first_part_number),
                            64'(rsp.first_part_number));
                check_field("family_echo", 64'(want.family_echo), 64'(rsp.family_echo));
                check_field("type_echo", 64'(want.type_echo), 64'(rsp.type_echo));
                check_field("lot_echo", 64'(want.lot_echo), 64'(rsp.lot_echo));
                check_field("table_full", 64'(want.table_full), 64'(rsp.table_full));
            end
        end
        req_taken <= rst_n && req_valid && req_ready;
    end

endmodule
